[hdl/hslc_pkg.sv]
// Shared types and constants of the RGB565 HSL color classifier.
package hslc_pkg;

    // Widths of the expanded channels and of the intermediate values.
    localparam int PIXEL_W     = 16;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 9;
    localparam int VAL_W       = 8;
    localparam int QUO_W       = 8;
    localparam int HUE_NUM_W   = 14;
    localparam int SAT_NUM_W   = 16;
    localparam int HUE_DEN_W   = CHAN_W;
    localparam int SAT_DEN_W   = SUM_W;
    localparam int CFG_INDEX_W = 3;

    // Scale limits and hue sector offsets.
    localparam logic [VAL_W-1:0] VAL_MAX        = 8'd240;
    localparam logic [VAL_W-1:0] HUE_WRAP       = 8'd240;
    localparam logic [VAL_W-1:0] HUE_GREEN_BASE = 8'd80;
    localparam logic [VAL_W-1:0] HUE_BLUE_BASE  = 8'd160;

    // Hue spans 40 steps per sector; saturation is scaled to 240.
    localparam logic [HUE_NUM_W-1:0] HUE_SECTOR = 14'd40;
    localparam logic [SAT_NUM_W-1:0] SAT_SCALE  = 16'd240;

    // Saturation uses sum as its denominator while luminance is at most 120,
    // which holds exactly for sum up to 257; above that it uses 511 - sum.
    localparam logic [SUM_W-1:0] SUM_SPAN         = 9'd511;
    localparam logic [SUM_W-1:0] SUM_LOW_HALF_MAX = 9'd257;

    // Luminance is floor(sum * 8 / 17); (sum * 3856) >> 13 is exact for sum <= 511.
    localparam int                   LUM_RECIP_W = 12;
    localparam logic [LUM_RECIP_W-1:0] LUM_RECIP = 12'd3856;
    localparam int                   LUM_SHIFT   = 13;
    localparam int                   LUM_PROD_W  = SUM_W + LUM_RECIP_W;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HUE_LOW  = 3'd0,
        REG_HUE_HIGH = 3'd1,
        REG_SAT_LOW  = 3'd2,
        REG_SAT_HIGH = 3'd3,
        REG_LUM_LOW  = 3'd4,
        REG_LUM_HIGH = 3'd5
    } cfg_index_t;

    // Match window registers.
    typedef struct packed {
        logic [VAL_W-1:0] hue_low;
        logic [VAL_W-1:0] hue_high;
        logic [VAL_W-1:0] sat_low;
        logic [VAL_W-1:0] sat_high;
        logic [VAL_W-1:0] lum_low;
        logic [VAL_W-1:0] lum_high;
    } thresh_t;

    // Values that ride alongside the divisions.
    typedef struct packed {
        logic [VAL_W-1:0] base;
        logic             neg;
        logic             grey;
        logic [VAL_W-1:0] lum;
    } side_t;

    // Operands handed to the divider.
    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [SAT_DEN_W-1:0] sat_den;
        side_t                side;
    } div_req_t;

    // Quotients returned by the divider.
    typedef struct packed {
        logic [QUO_W-1:0] hue_q;
        logic [QUO_W-1:0] sat_q;
        side_t            side;
    } div_rsp_t;

endpackage

[hdl/rgb565_hsl_color_classifier_unit.sv]
// Top level of the RGB565 HSL color classifier with its match window registers.
//
// Converts each RGB565 pixel beat to hue, saturation and luminance on a 0..240 scale
// and flags a match when all three lie strictly inside the programmed windows. One pixel
// is accepted every clock unless the output stalls; a beat passes through two front-end
// stages, an eight-stage restoring divider that settles one quotient bit per stage, and
// one registered output stage. Backpressure stalls only the stages that are full, so
// bubbles are squeezed out. The six window registers are written through the plain
// write port at indexes 0 to 5 and should only change while no beat is in flight.
module rgb565_hsl_color_classifier_unit import hslc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PIXEL_W-1:0]     s_pixel,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VAL_W-1:0]       m_hue,
    output logic [VAL_W-1:0]       m_saturation,
    output logic [VAL_W-1:0]       m_luminance,
    output logic                   m_matched,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]       cfg_wr_data
);

    thresh_t thresh_reg, thresh_next;

    logic     front_valid;
    logic     front_ready;
    div_req_t front_req;
    logic     div_valid;
    logic     div_ready;
    div_rsp_t div_rsp;

    // Window register writes; indexes beyond the list are ignored.
    always_comb begin
        thresh_next = thresh_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_HUE_LOW:  thresh_next.hue_low  = cfg_wr_data;
                REG_HUE_HIGH: thresh_next.hue_high = cfg_wr_data;
                REG_SAT_LOW:  thresh_next.sat_low  = cfg_wr_data;
                REG_SAT_HIGH: thresh_next.sat_high = cfg_wr_data;
                REG_LUM_LOW:  thresh_next.lum_low  = cfg_wr_data;
                REG_LUM_HIGH: thresh_next.lum_high = cfg_wr_data;
                default:      thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg.hue_low  <= '0;
            thresh_reg.hue_high <= VAL_MAX;
            thresh_reg.sat_low  <= '0;
            thresh_reg.sat_high <= VAL_MAX;
            thresh_reg.lum_low  <= '0;
            thresh_reg.lum_high <= VAL_MAX;
        end else begin
            thresh_reg <= thresh_next;
        end
    end

    // Channel expansion and operand setup.
    hslc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pixel  (s_pixel),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_req   (front_req)
    );

    // Hue and saturation division.
    hslc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_req    (front_req),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_rsp   (div_rsp)
    );

    // Result assembly and window match.
    hslc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (div_valid),
        .in_ready       (div_ready),
        .in_rsp         (div_rsp),
        .thresh         (thresh_reg),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_hue        (m_hue),
        .out_saturation (m_saturation),
        .out_luminance  (m_luminance),
        .out_matched    (m_matched)
    );

endmodule

[hdl/hslc_front.sv]
// Front end: channel expansion, max/min, hue sector and divider operands in two stages.
module hslc_front import hslc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIXEL_W-1:0] in_pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output div_req_t           out_req
);

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // Stage one registers.
    logic              s1_vld_reg;
    logic [CHAN_W-1:0] s1_d_reg,   s1_d_next;
    logic [SUM_W-1:0]  s1_sum_reg, s1_sum_next;
    logic [CHAN_W-1:0] s1_mag_reg, s1_mag_next;
    logic              s1_neg_reg, s1_neg_next;
    sector_t           s1_sect_reg, s1_sect_next;

    // Stage two registers.
    logic     s2_vld_reg;
    div_req_t s2_req_reg, s2_req_next;

    logic adv1;
    logic adv2;

    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] opa;
    logic [CHAN_W-1:0] opb;

    logic [LUM_PROD_W-1:0] lum_prod;

    // A stage loads when it is empty or its content moves on.
    assign adv2     = !s2_vld_reg || out_ready;
    assign adv1     = !s1_vld_reg || adv2;
    assign in_ready = adv1;

    // Expand the pixel, find max and min, and pick the hue sector (red checked first).
    always_comb begin
        red   = {in_pixel[15:11], 3'b000};
        green = {in_pixel[10:5], 2'b00};
        blue  = {in_pixel[4:0], 3'b000};
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        if (mx == red) begin
            s1_sect_next = SECT_RED;
            opa = green;
            opb = blue;
        end else if (mx == green) begin
            s1_sect_next = SECT_GREEN;
            opa = blue;
            opb = red;
        end else begin
            s1_sect_next = SECT_BLUE;
            opa = red;
            opb = green;
        end
        s1_neg_next = opa < opb;
        s1_mag_next = s1_neg_next ? (opb - opa) : (opa - opb);
        s1_d_next   = mx - mn;
        s1_sum_next = SUM_W'(mx) + SUM_W'(mn);
    end

    // Build the numerators, denominators, hue base and luminance.
    always_comb begin
        lum_prod = LUM_PROD_W'(s1_sum_reg) * LUM_PROD_W'(LUM_RECIP);
        s2_req_next.hue_num = HUE_NUM_W'(s1_mag_reg) * HUE_SECTOR;
        s2_req_next.hue_den = s1_d_reg;
        s2_req_next.sat_num = SAT_NUM_W'(s1_d_reg) * SAT_SCALE;
        s2_req_next.sat_den = (s1_sum_reg <= SUM_LOW_HALF_MAX) ? s1_sum_reg
                                                               : (SUM_SPAN - s1_sum_reg);
        s2_req_next.side.neg  = s1_neg_reg;
        s2_req_next.side.grey = (s1_d_reg == '0);
        s2_req_next.side.lum  = lum_prod[LUM_SHIFT +: VAL_W];
        unique case (s1_sect_reg)
            SECT_RED:   s2_req_next.side.base = s1_neg_reg ? HUE_WRAP : '0;
            SECT_GREEN: s2_req_next.side.base = HUE_GREEN_BASE;
            SECT_BLUE:  s2_req_next.side.base = HUE_BLUE_BASE;
            default:    s2_req_next.side.base = '0;
        endcase
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            if (adv1) s1_vld_reg <= in_valid;
            if (adv2) s2_vld_reg <= s1_vld_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            s1_d_reg    <= s1_d_next;
            s1_sum_reg  <= s1_sum_next;
            s1_mag_reg  <= s1_mag_next;
            s1_neg_reg  <= s1_neg_next;
            s1_sect_reg <= s1_sect_next;
        end
        if (adv2 && s1_vld_reg) begin
            s2_req_reg <= s2_req_next;
        end
    end

    assign out_valid = s2_vld_reg;
    assign out_req   = s2_req_reg;

`ifndef SYNTH
    // A colored pixel never reaches the divider with a zero or too small divisor.
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_vld_reg && !s2_req_reg.side.grey |->
            (s2_req_reg.hue_den != '0) &&
            (s2_req_reg.sat_den >= SAT_DEN_W'(s2_req_reg.hue_den)))
        else $error("divider operands out of range");
`endif

endmodule

[hdl/hslc_div.sv]
// Pipelined restoring divider for hue and saturation, one quotient bit per stage.
module hslc_div import hslc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  div_req_t in_req,
    output logic     out_valid,
    input  logic     out_ready,
    output div_rsp_t out_rsp
);

    localparam int HT_W = HUE_DEN_W + QUO_W;
    localparam int ST_W = SAT_DEN_W + QUO_W;

    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_rem;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [QUO_W-1:0]     hue_q;
        logic [SAT_NUM_W-1:0] sat_rem;
        logic [SAT_DEN_W-1:0] sat_den;
        logic [QUO_W-1:0]     sat_q;
        side_t                side;
    } dstage_t;

    dstage_t stg_in   [QUO_W];
    dstage_t stg_next [QUO_W];
    dstage_t stg_reg  [QUO_W];
    logic    vld_in      [QUO_W];
    logic    stg_vld_reg [QUO_W];
    logic    adv [QUO_W+1];

    assign adv[QUO_W] = out_ready;
    assign in_ready   = adv[0];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;

        logic [HT_W-1:0] hue_trial;
        logic [ST_W-1:0] sat_trial;
        logic            hue_fit;
        logic            sat_fit;

        // Stage input comes from the port or from the stage before.
        if (k == 0) begin : g_first
            always_comb begin
                stg_in[k].hue_rem = in_req.hue_num;
                stg_in[k].hue_den = in_req.hue_den;
                stg_in[k].hue_q   = '0;
                stg_in[k].sat_rem = in_req.sat_num;
                stg_in[k].sat_den = in_req.sat_den;
                stg_in[k].sat_q   = '0;
                stg_in[k].side    = in_req.side;
            end
            assign vld_in[k] = in_valid;
        end else begin : g_next
            assign stg_in[k] = stg_reg[k-1];
            assign vld_in[k] = stg_vld_reg[k-1];
        end

        assign adv[k] = !stg_vld_reg[k] || adv[k+1];

        // Try to subtract the shifted divisor from each partial remainder.
        assign hue_trial = HT_W'(stg_in[k].hue_den) << BIT;
        assign sat_trial = ST_W'(stg_in[k].sat_den) << BIT;
        assign hue_fit   = HT_W'(stg_in[k].hue_rem) >= hue_trial;
        assign sat_fit   = ST_W'(stg_in[k].sat_rem) >= sat_trial;

        always_comb begin
            stg_next[k] = stg_in[k];
            if (hue_fit) begin
                stg_next[k].hue_rem  = HUE_NUM_W'(HT_W'(stg_in[k].hue_rem) - hue_trial);
                stg_next[k].hue_q[BIT] = 1'b1;
            end
            if (sat_fit) begin
                stg_next[k].sat_rem  = SAT_NUM_W'(ST_W'(stg_in[k].sat_rem) - sat_trial);
                stg_next[k].sat_q[BIT] = 1'b1;
            end
        end

        // Valid bit of this stage.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_vld_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                stg_vld_reg[k] <= vld_in[k];
            end
        end

        // Payload of this stage.
        always_ff @(posedge aclk) begin
            if (adv[k] && vld_in[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_valid     = stg_vld_reg[QUO_W-1];
    assign out_rsp.hue_q = stg_reg[QUO_W-1].hue_q;
    assign out_rsp.sat_q = stg_reg[QUO_W-1].sat_q;
    assign out_rsp.side  = stg_reg[QUO_W-1].side;

`ifndef SYNTH
    // After the last stage each remainder is below its divisor.
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_vld_reg[QUO_W-1] && !stg_reg[QUO_W-1].side.grey |->
            (stg_reg[QUO_W-1].hue_rem < HUE_NUM_W'(stg_reg[QUO_W-1].hue_den)) &&
            (stg_reg[QUO_W-1].sat_rem < SAT_NUM_W'(stg_reg[QUO_W-1].sat_den)))
        else $error("division did not converge");

    // An accepted beat occupies the first stage on the next cycle.
    a_first_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> stg_vld_reg[0])
        else $error("accepted beat lost at divider entry");
`endif

endmodule

[hdl/hslc_back.sv]
// Output stage: hue assembly, clamping and window match, registered toward the port.
module hslc_back import hslc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  div_rsp_t         in_rsp,
    input  thresh_t          thresh,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [VAL_W-1:0] out_hue,
    output logic [VAL_W-1:0] out_saturation,
    output logic [VAL_W-1:0] out_luminance,
    output logic             out_matched
);

    logic             vld_reg;
    logic [VAL_W-1:0] hue_reg, hue_next;
    logic [VAL_W-1:0] sat_reg, sat_next;
    logic [VAL_W-1:0] lum_reg, lum_next;
    logic             match_reg, match_next;
    logic             adv;

    assign adv      = !vld_reg || out_ready;
    assign in_ready = adv;

    // Offset the hue quotient into its sector, clamp, and test the windows.
    always_comb begin
        if (in_rsp.side.grey) begin
            hue_next = '0;
            sat_next = '0;
        end else begin
            hue_next = in_rsp.side.neg ? (in_rsp.side.base - in_rsp.hue_q)
                                       : (in_rsp.side.base + in_rsp.hue_q);
            sat_next = (in_rsp.sat_q > VAL_MAX) ? VAL_MAX : in_rsp.sat_q;
        end
        lum_next   = (in_rsp.side.lum > VAL_MAX) ? VAL_MAX : in_rsp.side.lum;
        match_next = (hue_next > thresh.hue_low) && (hue_next < thresh.hue_high) &&
                     (sat_next > thresh.sat_low) && (sat_next < thresh.sat_high) &&
                     (lum_next > thresh.lum_low) && (lum_next < thresh.lum_high);
    end

    // Output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_valid;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            lum_reg   <= lum_next;
            match_reg <= match_next;
        end
    end

    assign out_valid      = vld_reg;
    assign out_hue        = hue_reg;
    assign out_saturation = sat_reg;
    assign out_luminance  = lum_reg;
    assign out_matched    = match_reg;

`ifndef SYNTH
    // Every delivered value stays on the 0..240 scale.
    a_in_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg |-> (hue_reg <= VAL_MAX) && (sat_reg <= VAL_MAX) && (lum_reg <= VAL_MAX))
        else $error("value beyond scale");

    // A match flag agrees with the windows it was tested against.
    a_match_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg && match_reg |->
            (hue_reg > thresh.hue_low) && (hue_reg < thresh.hue_high) &&
            (sat_reg > thresh.sat_low) && (sat_reg < thresh.sat_high) &&
            (lum_reg > thresh.lum_low) && (lum_reg < thresh.lum_high))
        else $error("match flag outside windows");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the RGB565 HSL color classifier unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hslc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 16;
    localparam int PHASE_BEATS    = 100;
    localparam int BURST_BEATS    = 12;

    // Indexes past the last window register; writes there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    // Two low bits of each color channel, used to jitter a pixel around a target.
    localparam logic [PIXEL_W-1:0] CHANNEL_LSB_MASK = 16'h1863;

    // One predicted classification, with the pixel kept for reporting.
    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic [VAL_W-1:0]   hue;
        logic [VAL_W-1:0]   sat;
        logic [VAL_W-1:0]   lum;
        logic               matched;
    } hsl_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [PIXEL_W-1:0]     s_pixel      = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [VAL_W-1:0]       m_hue;
    logic [VAL_W-1:0]       m_saturation;
    logic [VAL_W-1:0]       m_luminance;
    logic                   m_matched;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [VAL_W-1:0]       cfg_wr_data  = '0;

    // Local copy of the match windows, as the block should hold them.
    thresh_t window;
    hsl_t    pending_hsl [$];
    int      mismatches    = 0;
    int      quiet_cycles  = 0;
    bit      idle_inputs   = 1'b0;
    bit      stall_results = 1'b0;

    rgb565_hsl_color_classifier_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_luminance  (m_luminance),
        .m_matched    (m_matched),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [VAL_W-1:0] clamp_scale(input int v);
        if (v > 240) return VAL_MAX;
        if (v < 0) return '0;
        return v[VAL_W-1:0];
    endfunction

    // Expands the pixel, converts it to hue, saturation and luminance and
    // checks the three values against the current windows.
    function automatic hsl_t classify_pixel(input logic [PIXEL_W-1:0] px);
        int   red, green, blue, hi, lo, span, total, h, s, l;
        hsl_t res;
        red   = {px[15:11], 3'b000};
        green = {px[10:5], 2'b00};
        blue  = {px[4:0], 3'b000};
        hi    = (red > green) ? red : green;
        hi    = (blue > hi) ? blue : hi;
        lo    = (red < green) ? red : green;
        lo    = (blue < lo) ? blue : lo;
        span  = hi - lo;
        total = hi + lo;
        l     = total * 240 / 255 / 2;
        if (span == 0) begin
            h = 0;
            s = 0;
        end else begin
            // Red wins ties, then green; magenta-side reds wrap to the top.
            if (hi == red) begin
                h = 40 * (green - blue) / span;
                if (green < blue) h += 240;
            end else if (hi == green) begin
                h = 40 * (blue - red) / span + 80;
            end else begin
                h = 40 * (red - green) / span + 160;
            end
            // The lighter half measures against the distance to white.
            if (l != 0 && l <= 120) begin
                s = span * 240 / total;
            end else begin
                s = span * 240 / (511 - total);
            end
        end
        res.pixel   = px;
        res.hue     = clamp_scale(h);
        res.sat     = clamp_scale(s);
        res.lum     = clamp_scale(l);
        res.matched = res.hue > window.hue_low && res.hue < window.hue_high &&
                      res.sat > window.sat_low && res.sat < window.sat_high &&
                      res.lum > window.lum_low && res.lum < window.lum_high;
        return res;
    endfunction

    // Mostly uniform pixels, with true greys and pixels close to a target.
    function automatic logic [PIXEL_W-1:0] random_pixel(input logic [PIXEL_W-1:0] target);
        logic [4:0] level;
        int         pick;
        level = 5'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 60) return 16'($urandom);
        if (pick < 75) return {level, level, 1'b0, level};
        return target ^ (16'($urandom) & CHANNEL_LSB_MASK);
    endfunction

    // Window bounds that favor the edges of the register range.
    function automatic logic [VAL_W-1:0] pick_bound();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) return '0;
        if (pick < 4) return VAL_MAX;
        if (pick < 5) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [VAL_W-1:0] bound_below(input logic [VAL_W-1:0] v);
        int x;
        x = int'(v) - int'($urandom_range(0, 6));
        return (x < 0) ? 8'h00 : x[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] bound_above(input logic [VAL_W-1:0] v);
        int x;
        x = int'(v) + int'($urandom_range(0, 6));
        return (x > 255) ? 8'hFF : x[VAL_W-1:0];
    endfunction

    // One register write; the local window copy follows the same decode.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [VAL_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_HUE_LOW:  window.hue_low  = data;
            REG_HUE_HIGH: window.hue_high = data;
            REG_SAT_LOW:  window.sat_low  = data;
            REG_SAT_HIGH: window.sat_high = data;
            REG_LUM_LOW:  window.lum_low  = data;
            REG_LUM_HIGH: window.lum_high = data;
            default: ;
        endcase
    endtask

    task automatic set_window(input logic [VAL_W-1:0] hl, input logic [VAL_W-1:0] hh,
                              input logic [VAL_W-1:0] sl, input logic [VAL_W-1:0] sh,
                              input logic [VAL_W-1:0] ll, input logic [VAL_W-1:0] lh);
        write_reg(REG_HUE_LOW, hl);
        write_reg(REG_HUE_HIGH, hh);
        write_reg(REG_SAT_LOW, sl);
        write_reg(REG_SAT_HIGH, sh);
        write_reg(REG_LUM_LOW, ll);
        write_reg(REG_LUM_HIGH, lh);
    endtask

    // Narrow windows around the values of one pixel, so hits and misses both occur.
    task automatic aim_window(input logic [PIXEL_W-1:0] target);
        hsl_t goal;
        goal = classify_pixel(target);
        set_window(bound_below(goal.hue), bound_above(goal.hue),
                   bound_below(goal.sat), bound_above(goal.sat),
                   bound_below(goal.lum), bound_above(goal.lum));
    endtask

    // Offers one pixel beat and returns at the edge where it is taken.
    // Valid stays high on return so back-to-back beats need no extra edge.
    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        int gap;
        gap = idle_inputs ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering beats and lets every outstanding result come back.
    // It waits on a clock edge first so the last accepted beat is surely queued.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_hsl.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_burst(input int beats, input logic [PIXEL_W-1:0] target);
        for (int i = 0; i < beats; i++) send_pixel(random_pixel(target));
        drain_pipeline();
    endtask

    // Colors at the corners of the cube, the ties between channels, the hue
    // wrap, greys, and both sides of the saturation denominator switch.
    task automatic test_directed_pixels();
        logic [PIXEL_W-1:0] corners [0:19];
        corners = '{16'h0000, 16'hFFFF, 16'hFFDF, 16'h8410, 16'hF800,
                    16'h07E0, 16'h001F, 16'hFFE0, 16'h07FF, 16'hF81F,
                    16'h8400, 16'h0410, 16'h8010, 16'hF801, 16'h07E1,
                    16'h0001, 16'h0820, 16'h8430, 16'hF7DE, 16'h7BEF};
        idle_inputs   = 1'b0;
        stall_results = 1'b0;
        foreach (corners[i]) send_pixel(corners[i]);
        drain_pipeline();
    endtask

    // Closed windows, bounds above the scale, dropped writes to spare
    // indexes, and tight windows around one pixel.
    task automatic test_window_registers();
        logic [PIXEL_W-1:0] target;
        idle_inputs   = 1'b1;
        stall_results = 1'b1;
        // Low bounds at full scale leave nothing strictly inside.
        set_window(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        send_burst(BURST_BEATS, 16'hFFFF);
        // Upper bounds of zero close every window as well.
        set_window('0, '0, '0, '0, '0, '0);
        send_burst(BURST_BEATS, 16'h0000);
        // Bounds above the scale are compared exactly as written.
        set_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_burst(BURST_BEATS, 16'hF800);
        // Wide-open windows must survive writes to the spare indexes.
        set_window('0, 8'hFF, '0, 8'hFF, '0, 8'hFF);
        write_reg(REG_SPARE_6, 8'hFF);
        write_reg(REG_SPARE_7, 8'hFF);
        send_burst(BURST_BEATS, 16'h07E0);
        target = 16'($urandom);
        aim_window(target);
        send_burst(BURST_BEATS, target);
    endtask

    // Phases of random pixels, each with its own windows and idling mix.
    task automatic test_random_traffic();
        logic [PIXEL_W-1:0] target;
        for (int phase = 0; phase < PHASES; phase++) begin
            idle_inputs   = (phase % 2) == 1;
            stall_results = (phase % 4) >= 2;
            target        = 16'($urandom);
            case ($urandom_range(0, 3))
                0: aim_window(target);
                1: set_window(8'($urandom_range(0, 100)), 8'($urandom_range(140, 255)),
                              8'($urandom_range(0, 100)), 8'($urandom_range(140, 255)),
                              8'($urandom_range(0, 100)), 8'($urandom_range(140, 255)));
                2: set_window(pick_bound(), pick_bound(), pick_bound(),
                              pick_bound(), pick_bound(), pick_bound());
                default: set_window('0, VAL_MAX, '0, VAL_MAX, '0, VAL_MAX);
            endcase
            send_burst(PHASE_BEATS, target);
        end
    endtask

    // Receiver side: runs of ready high broken by random stalls.
    initial begin : result_backpressure
        int stall;
        @(posedge aclk);
        forever begin
            stall = stall_results ? gap_len() : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // Every accepted pixel beat queues its predicted classification.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) pending_hsl.push_back(classify_pixel(s_pixel));
    end

    // Every accepted result beat is compared with the oldest prediction.
    always @(posedge aclk) begin : result_check
        hsl_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hsl.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: hue %0d sat %0d lum %0d matched %0b",
                             m_hue, m_saturation, m_luminance, m_matched);
            end else begin
                want = pending_hsl.pop_front();
                if (m_hue !== want.hue || m_saturation !== want.sat ||
                    m_luminance !== want.lum || m_matched !== want.matched) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"pixel %h: expected hue %0d sat %0d lum %0d matched %0b, ",
                                  "got hue %0d sat %0d lum %0d matched %0b"},
                                 want.pixel, want.hue, want.sat, want.lum, want.matched,
                                 m_hue, m_saturation, m_luminance, m_matched);
                end
            end
        end
    end

    // Ends the run when no beat moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        window = '{hue_low: '0, hue_high: VAL_MAX, sat_low: '0, sat_high: VAL_MAX,
                   lum_low: '0, lum_high: VAL_MAX};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_pixels();
        test_window_registers();
        test_random_traffic();
        if (mismatches == 0 && pending_hsl.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
